// ===== design/tfbs_pkg.sv =====
// Package for the tape FSK bit serialiser: command codes, framing constants
// and the reset value of the leader length register. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tfbs_pkg;

   localparam int unsigned LeaderWidth  = 14;
   localparam int unsigned BitsWidth    = 4;
   localparam int unsigned TicksWidth   = 5;
   localparam int unsigned FrameWidth   = 10;
   localparam int unsigned ByteWidth    = 8;

   localparam logic [LeaderWidth-1:0] LEADER_RESET  = 14'd15000;
   localparam logic [BitsWidth-1:0]   FRAME_BITS    = 4'd10;
   localparam logic [TicksWidth-1:0]  TICKS_PER_BIT = 5'd16;
   localparam logic [FrameWidth-1:0]  STOP_MARK     = 10'h200;

   typedef enum logic [1:0] {
      CMD_TICK       = 2'd0,
      CMD_LOAD_BYTE  = 2'd1,
      CMD_LEADER_ON  = 2'd2,
      CMD_LEADER_OFF = 2'd3
   } cmd_type;

endpackage

`default_nettype wire

// ===== design/tape_fsk_bit_serializer_top.sv =====
// Top level of the tape FSK bit serialiser: input register, tone and framing
// update logic and result register. Depends on tfbs_pkg.
//
// Usage: each item on the req_ channel is a command (tick, load byte, leader
// on, leader off) and produces exactly one result item on the rsp_ channel,
// carrying the tape level, the reference tone bit and the data request flag.
// An item is taken at a rising edge where its valid is high and its stall is
// low. The accepted item is held in an input register and processed from
// there, when the state and the result register are updated; the result is
// then on the rsp_ channel from the result register. One item is taken every
// cycle while the receiver keeps rsp_stall low; the sustained rate is set by
// the single state update stage. When the receiver stalls, the result
// register holds and the input register fills, after which req_stall rises.
// The leader length register is written on the csr_ channel, which is
// always ready; write it only while no items are in flight.
// Reset (synchronous, active high) empties both registers, clears the tape
// level, tone bit and all counters and sets the leader length to 15000.
`timescale 1ns / 1ps
`default_nettype none

module tape_fsk_bit_serializer_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_stall,
   input  wire logic [1:0]                         req_cmd,
   input  wire logic [tfbs_pkg::ByteWidth-1:0]     req_byte_value,
   input  wire logic                               req_motor_on,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   output      logic                               rsp_tape_level,
   output      logic                               rsp_tone_ref,
   output      logic                               rsp_want_data,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [tfbs_pkg::LeaderWidth-1:0]   csr_leader_ticks
);
   import tfbs_pkg::*;

   logic                    in_valid_ff;
   cmd_type                 in_cmd_ff;
   logic [ByteWidth-1:0]    in_byte_ff;
   logic                    in_motor_ff;

   logic                    out_valid_ff;
   logic                    out_level_ff;
   logic                    out_tone_ff;
   logic                    out_want_ff;

   logic [LeaderWidth-1:0]  leader_ticks_ff;
   logic [LeaderWidth-1:0]  leader_left_ff, leader_left_in;
   logic [BitsWidth-1:0]    bits_left_ff, bits_left_in;
   logic [TicksWidth-1:0]   ticks_left_ff, ticks_left_in;
   logic [FrameWidth-1:0]   frame_shift_ff, frame_shift_in;
   logic                    level_ff, level_in;
   logic                    tone_bit_ff, tone_bit_in;
   logic                    want_in;

   logic                    out_load;
   logic                    advance;
   logic                    take;
   logic [LeaderWidth-1:0]  leader_dec;
   logic [TicksWidth-1:0]   ticks_dec;
   logic [BitsWidth-1:0]    bits_dec;

   assign out_load  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_load;
   assign req_stall = in_valid_ff && !out_load;
   assign take      = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid      = out_valid_ff;
   assign rsp_tape_level = out_level_ff;
   assign rsp_tone_ref   = out_tone_ff;
   assign rsp_want_data  = out_want_ff;

   assign leader_dec = leader_left_ff - 1'b1;
   assign ticks_dec  = ticks_left_ff - 1'b1;
   assign bits_dec   = bits_left_ff - 1'b1;

   always_comb begin
      leader_left_in = leader_left_ff;
      bits_left_in   = bits_left_ff;
      ticks_left_in  = ticks_left_ff;
      frame_shift_in = frame_shift_ff;
      level_in       = level_ff;
      tone_bit_in    = tone_bit_ff;
      want_in        = 1'b0;
      unique case (in_cmd_ff)
         CMD_TICK: begin
            tone_bit_in = !tone_bit_ff;
            if (in_motor_ff) begin
               if (leader_left_ff != '0) begin
                  leader_left_in = leader_dec;
                  level_in       = leader_dec[0];
                  want_in        = (leader_dec == '0);
               end else if (bits_left_ff != '0) begin
                  level_in      = frame_shift_ff[0] ? ticks_left_ff[0] : ticks_left_ff[1];
                  ticks_left_in = ticks_dec;
                  if (ticks_dec == '0) begin
                     bits_left_in   = bits_dec;
                     frame_shift_in = frame_shift_ff >> 1;
                     if (bits_dec == '0) begin
                        want_in = 1'b1;
                     end else begin
                        ticks_left_in = TICKS_PER_BIT;
                     end
                  end
               end else begin
                  want_in = 1'b1;
               end
            end
         end
         CMD_LOAD_BYTE: begin
            bits_left_in   = FRAME_BITS;
            ticks_left_in  = TICKS_PER_BIT;
            frame_shift_in = STOP_MARK | {1'b0, in_byte_ff, 1'b0};
         end
         CMD_LEADER_ON: begin
            leader_left_in = leader_ticks_ff;
         end
         CMD_LEADER_OFF: begin
            leader_left_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         leader_ticks_ff <= LEADER_RESET;
         leader_left_ff  <= '0;
         bits_left_ff    <= '0;
         ticks_left_ff   <= '0;
         frame_shift_ff  <= '0;
         level_ff        <= 1'b0;
         tone_bit_ff     <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            leader_ticks_ff <= csr_leader_ticks;
         end
         if (take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (out_load) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            leader_left_ff <= leader_left_in;
            bits_left_ff   <= bits_left_in;
            ticks_left_ff  <= ticks_left_in;
            frame_shift_ff <= frame_shift_in;
            level_ff       <= level_in;
            tone_bit_ff    <= tone_bit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_cmd_ff   <= cmd_type'(req_cmd);
         in_byte_ff  <= req_byte_value;
         in_motor_ff <= req_motor_on;
      end
      if (advance) begin
         out_level_ff <= level_in;
         out_tone_ff  <= tone_bit_in;
         out_want_ff  <= want_in;
      end
   end

   // The frame counter never exceeds the length of one frame.
   a_bits_bounded: assert property (@(posedge clock) disable iff (reset)
      bits_left_ff <= FRAME_BITS)
      else $error("frame bit counter out of range");

   // While frame bits are pending, the tick counter lies within one bit time.
   a_ticks_in_bit: assert property (@(posedge clock) disable iff (reset)
      (bits_left_ff != '0) |-> (ticks_left_ff != '0 && ticks_left_ff <= TICKS_PER_BIT))
      else $error("tick counter out of range while a frame is pending");

   // Only a tick item changes the reference tone bit.
   a_tone_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      (advance && in_cmd_ff != CMD_TICK) |=> $stable(tone_bit_ff))
      else $error("tone bit changed on a non-tick item");

   // An item leaving the input register always appears as a result.
   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed item produced no result");

   // The input side is only held off when the input register is occupied.
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with an empty input register");

endmodule

`default_nettype wire
